// ===== src/hrve_pkg.sv =====
// shared types and constants for the hex record version extractor
// no dependencies; imported by the parser and the top level
`timescale 1ns / 1ps
`default_nettype none

package hrve_pkg;

   localparam int unsigned MARKER_CHARS = 15;
   localparam int unsigned POS_WIDTH    = 10;

   // extended-address record that announces the version record, first char in the msbs
   localparam logic [MARKER_CHARS*8-1:0] MARKER_TEXT = ":020000040020DA";

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_COLON = 8'h3A;

   localparam logic [7:0]           MAX_LENGTH = 8'd251;
   localparam logic [POS_WIDTH-1:0] POS_MAX    = '1;

   // version status after one character, also the result transaction contents
   typedef struct packed {
      logic        version_valid;
      logic [15:0] major_version;
      logic [15:0] minor_version;
      logic        parse_stopped;
   } status_type;

endpackage

`default_nettype wire

// ===== src/hrve_parser.sv =====
// per-character parser state and its combinational next-state logic
// depends on hrve_pkg
`timescale 1ns / 1ps
`default_nettype none

module hrve_parser (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step_en,
   input  wire logic [7:0]          text_char,
   input  wire logic                final_char,
   output hrve_pkg::status_type     status
);
   import hrve_pkg::*;

   typedef struct packed {
      logic [7:0]      rec_len;
      logic [7:0]      byte_sum;
      logic [3:0][7:0] data;
      logic            rec_done;
      logic            stopped;
      logic            ver_valid;
      logic [15:0]     ver_major;
      logic [15:0]     ver_minor;
   } rec_state_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_decode(logic [7:0] c);
      hex_digit_type h;
      h = '0;
      if (c >= "0" && c <= "9") begin
         h.ok    = 1'b1;
         h.value = 4'(c - "0");
      end else if (c >= "A" && c <= "F") begin
         h.ok    = 1'b1;
         h.value = 4'(c - "A" + 8'd10);
      end else if (c >= "a" && c <= "f") begin
         h.ok    = 1'b1;
         h.value = 4'(c - "a" + 8'd10);
      end
      return h;
   endfunction

   function automatic rec_state_type finish_record(rec_state_type s, logic [7:0] cks);
      rec_state_type r;
      r = s;
      r.rec_done = 1'b1;
      if (8'(8'd0 - s.byte_sum) == cks) begin
         r.ver_valid = 1'b1;
         r.ver_major = {s.data[1], s.data[0]};
         r.ver_minor = {s.data[3], s.data[2]};
      end else begin
         r.stopped = 1'b1;
      end
      return r;
   endfunction

   // one record byte: length, then address/type/data into the sum, then the checksum
   function automatic rec_state_type add_byte(rec_state_type s, logic [8:0] idx,
                                              logic [7:0] val);
      rec_state_type r;
      logic [8:0]    lim;
      r   = s;
      lim = {1'b0, s.rec_len} + 9'd4;
      if (idx == '0) begin
         r.rec_len = val;
         if (val > MAX_LENGTH) begin
            r.stopped = 1'b1;
         end else begin
            r.byte_sum = 8'(s.byte_sum + val);
         end
      end else if (idx < lim) begin
         r.byte_sum = 8'(s.byte_sum + val);
         if (idx[8:2] == 7'd1) begin
            r.data[idx[1:0]] = val;
         end
      end else if (idx == lim) begin
         r = finish_record(s, val);
      end
      return r;
   endfunction

   rec_state_type              rec_ff, rec_in;
   logic [MARKER_CHARS*8-1:0]  recent_ff, recent_in;
   logic [POS_WIDTH-1:0]       pos_ff, pos_in;
   logic [3:0]                 high_ff, high_in;
   logic                       marker_ff, marker_in;
   logic                       expect_ff, expect_in;
   logic                       cr_ff, cr_in;

   hex_digit_type              hex_v;
   logic [POS_WIDTH-1:0]       digits;
   logic [POS_WIDTH-1:0]       end_digits;
   logic [MARKER_CHARS*8-1:0]  shifted;
   logic                       line_end;

   assign hex_v   = hex_decode(text_char);
   assign digits  = pos_ff - 1'b1;
   assign shifted = {recent_ff[(MARKER_CHARS-1)*8-1:0], text_char};

   always_comb begin
      rec_in     = rec_ff;
      recent_in  = recent_ff;
      pos_in     = pos_ff;
      high_in    = high_ff;
      marker_in  = marker_ff;
      expect_in  = expect_ff;
      cr_in      = cr_ff;
      line_end   = 1'b0;
      end_digits = '0;

      if (step_en && !rec_ff.stopped) begin
         if (cr_ff) begin
            // a held carriage return is only legal right before the newline
            cr_in = 1'b0;
            if (text_char == CH_LF) begin
               line_end = 1'b1;
            end else begin
               rec_in.stopped = 1'b1;
            end
         end else if (text_char == CH_LF) begin
            if (pos_ff == '0) begin
               rec_in.stopped = 1'b1;
            end else begin
               line_end = 1'b1;
            end
         end else begin
            if (pos_ff == '0) begin
               if (text_char != CH_COLON) begin
                  rec_in.stopped = 1'b1;
               end else begin
                  pos_in = POS_WIDTH'(1);
                  if (!expect_ff) begin
                     recent_in = shifted;
                     if (shifted == MARKER_TEXT) marker_in = 1'b1;
                  end
               end
            end else if (expect_ff) begin
               if (!rec_ff.rec_done) begin
                  if (text_char == CH_CR) begin
                     cr_in = 1'b1;
                  end else if (!hex_v.ok) begin
                     rec_in.stopped = 1'b1;
                  end else begin
                     if (!digits[0]) begin
                        high_in = hex_v.value;
                     end else begin
                        rec_in = add_byte(rec_ff, digits[POS_WIDTH-1:1],
                                          {high_ff, hex_v.value});
                     end
                     if (pos_ff != POS_MAX) pos_in = pos_ff + 1'b1;
                  end
               end
            end else begin
               recent_in = shifted;
               if (shifted == MARKER_TEXT) marker_in = 1'b1;
               if (pos_ff != POS_MAX) pos_in = pos_ff + 1'b1;
            end
            if (final_char && !rec_in.stopped) line_end = 1'b1;
         end
      end

      if (line_end) begin
         end_digits = pos_in - 1'b1;
         if (expect_ff) begin
            // short record: lone digit is a byte, missing bytes read as zero
            if (!rec_in.rec_done && !rec_in.stopped) begin
               if (end_digits[0]) begin
                  rec_in = add_byte(rec_in, end_digits[POS_WIDTH-1:1], {4'd0, high_in});
               end
               if (!rec_in.rec_done && !rec_in.stopped) begin
                  rec_in = finish_record(rec_in, 8'd0);
               end
            end
            expect_in = 1'b0;
         end else if (marker_in) begin
            if (final_char) begin
               rec_in.stopped = 1'b1;
            end else begin
               expect_in = 1'b1;
            end
         end
         recent_in       = '0;
         pos_in          = '0;
         marker_in       = 1'b0;
         high_in         = '0;
         cr_in           = 1'b0;
         rec_in.rec_len  = '0;
         rec_in.byte_sum = '0;
         rec_in.data     = '0;
         rec_in.rec_done = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff    <= '0;
         recent_ff <= '0;
         pos_ff    <= '0;
         high_ff   <= '0;
         marker_ff <= 1'b0;
         expect_ff <= 1'b0;
         cr_ff     <= 1'b0;
      end else begin
         rec_ff    <= rec_in;
         recent_ff <= recent_in;
         pos_ff    <= pos_in;
         high_ff   <= high_in;
         marker_ff <= marker_in;
         expect_ff <= expect_in;
         cr_ff     <= cr_in;
      end
   end

   // field order of status_type: valid, major, minor, stopped
   assign status = {rec_in.ver_valid, rec_in.ver_major, rec_in.ver_minor, rec_in.stopped};

endmodule

`default_nettype wire

// ===== src/hex_record_version_extractor_unit.sv =====
// top level of the hex record version extractor: stream ports and result register
// depends on hrve_pkg and hrve_parser
`timescale 1ns / 1ps
`default_nettype none

// Takes Intel HEX text one character per req transaction (tlast marks the last
// character of the text) and returns one rsp transaction per character with the
// version status after that character. A line holding the record ":020000040020DA"
// makes the next line a version record; when its checksum matches, major and minor
// come from data bytes 0-1 and 2-3, little endian, and version_valid is set. A bad
// first character, bad checksum, bad hex digit, record length above 251, carriage return
// not followed by a newline, empty line or marker on the final line sets parse_stopped for
// good and later characters change nothing. Throughput is one character per clock while
// rsp is free or being drained: every character is handled by one pass of the parser's
// next-state logic into its state registers and the rsp register, so the response shows
// up in the cycle after the character is accepted. No clearing pass is needed after reset.
module hex_record_version_extractor_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] text_char
   input  wire logic        req_tlast,   // final_char
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [15:0] major_version, [31:16] minor_version
   output logic [1:0]       rsp_tuser    // [0] version_valid, [1] parse_stopped
);
   import hrve_pkg::*;

   logic       req_accept;
   status_type next_status;
   status_type rsp_status_ff, rsp_status_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // take a character whenever the result register is empty or drains this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   hrve_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step_en    (req_accept),
      .text_char  (req_tdata),
      .final_char (req_tlast),
      .status     (next_status)
   );

   // result register holds status after the accepted character
   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      if (req_accept) begin
         rsp_status_in = next_status;
         rsp_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload only, no reset needed
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_status_ff.minor_version, rsp_status_ff.major_version};
   assign rsp_tuser  = {rsp_status_ff.parse_stopped, rsp_status_ff.version_valid};

endmodule

`default_nettype wire

// ===== src/hrve_port_checker.sv =====
// port-level checks for the hex record version extractor, bound to the top level
// depends on hex_record_version_extractor_unit
`timescale 1ns / 1ps
`default_nettype none

module hrve_port_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);
   logic stopped_seen_ff, stopped_seen_in;

   assign stopped_seen_in = stopped_seen_ff || (rsp_tvalid && rsp_tready && rsp_tuser[1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         stopped_seen_ff <= 1'b0;
      end else begin
         stopped_seen_ff <= stopped_seen_in;
      end
   end

   // every accepted character yields a response in the next cycle
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("no response after accepted request");

   // a new response only appears after an accepted request
   a_no_invented_rsp: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid ##1 rsp_tvalid |-> $past(req_tvalid && req_tready))
      else $error("response without request");

   // stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // once a stop has been delivered, every later response keeps it
   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && stopped_seen_ff |-> rsp_tuser[1])
      else $error("parse_stopped cleared after being reported");

endmodule

bind hex_record_version_extractor_unit hrve_port_checker u_hrve_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
